[design/hufd_pkg.sv]
// ----------------------------------------------------------------------------
// hufd_pkg
// Shared types and codes for the tree-walk huffman decoder: command codes,
// result kinds, the tree node layout and the queued command word.
// ----------------------------------------------------------------------------
`default_nettype none

package hufd_pkg;

    // field widths fixed by the stream format
    localparam int IDX_W   = 9;
    localparam int SYM_W   = 8;
    localparam int CNT_W   = 48;
    localparam int CODE_W  = 64;
    localparam int IN_W    = 96;

    // input command codes (carried in tuser)
    typedef logic [1:0] t_func;
    localparam t_func FUNC_LOAD   = 2'd0;
    localparam t_func FUNC_DECODE = 2'd1;
    localparam t_func FUNC_END    = 2'd2;

    // result kinds (carried in tuser)
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_SYMBOL = 2'd0;
    localparam t_kind KIND_TRUNC  = 2'd1;
    localparam t_kind KIND_DONE   = 2'd2;

    // one stored tree node, a right link of zero marks a leaf
    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } t_node;

    // classified command handed from front to back
    typedef struct packed {
        t_func             func;
        logic [IDX_W-1:0]  idx;
        t_node             node;
        logic [CODE_W-1:0] code;
    } t_cmd;

endpackage

`default_nettype wire

[design/huffman_tree_bit_decoder.sv]
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder
// Huffman decoder; walks a stored code tree one code bit per unstalled cycle.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis; tuser selects node load, decode or end of
// input. Loads write the node table, decode words are walked bit by bit from
// the least significant bit, and end of input reports completion or
// truncation. Results leave on m_axis: tdata is the symbol, tuser the kind,
// tlast marks the final result of one input word.
// A two-entry queue sits between the input side and the walker, so input is
// taken while the walker runs or the output waits.
// Each decode bit depends on the node reached by the bit before, and the
// node table has one registered read port. Each symbol of a word is held
// until the next one, or the end of the word, decides its tlast.
// Reset clears the symbol count, the walk position and total_symbols; the node
// table holds nothing until loaded. A stalled receiver holds the walker, which
// in turn fills the queue and drops s_axis_tready. The user, not the block,
// keeps total_symbols writes through i_cfg_wr_en / i_cfg_wr_data to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_tree_bit_decoder #(
    parameter int NODE_COUNT = 512,
    parameter int WORD_BITS  = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // node_index [8:0], left_value [17:9], right_value [26:18],
    // code_word [90:27], zero [95:91]
    input  wire logic [95:0] s_axis_tdata,
    // func [1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // symbol [7:0]
    output logic [7:0]       m_axis_tdata,
    // kind [1:0]
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [47:0] i_cfg_wr_data
);

    logic           cmd_valid;
    hufd_pkg::t_cmd cmd;
    logic           cmd_pop;

    // input side and command queue
    hufd_front #(
        .NODE_COUNT (NODE_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_func    (s_axis_tuser),
        .i_s_data    (s_axis_tdata),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // tree walker and result register
    hufd_back #(
        .NODE_COUNT (NODE_COUNT),
        .WORD_BITS  (WORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .o_m_sym       (m_axis_tdata),
        .o_m_kind      (m_axis_tuser),
        .o_m_last      (m_axis_tlast)
    );

endmodule

`default_nettype wire

[design/hufd_ram.sv]
// ----------------------------------------------------------------------------
// hufd_ram
// Generic single-write, single-read RAM with a registered read port that
// holds its data while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module hufd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/hufd_front.sv]
// ----------------------------------------------------------------------------
// hufd_front
// Input side: accepts words, drops unused codes and out-of-range node loads,
// and queues the remaining commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hufd_front #(
    parameter int NODE_COUNT = 512
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire hufd_pkg::t_func             i_s_func,
    input  wire logic [hufd_pkg::IN_W-1:0]   i_s_data,
    output logic                             o_cmd_valid,
    output hufd_pkg::t_cmd                   o_cmd,
    input  wire logic                        i_cmd_pop
);

    localparam logic [hufd_pkg::IDX_W:0] NodeLimit = (hufd_pkg::IDX_W + 1)'(NODE_COUNT);

    hufd_pkg::t_cmd r_q [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    hufd_pkg::t_cmd in_cmd;
    logic           keep;
    logic           push;
    logic           pop;

    // unpack the incoming word
    always_comb begin
        in_cmd.func       = i_s_func;
        in_cmd.idx        = i_s_data[8:0];
        in_cmd.node.left  = i_s_data[17:9];
        in_cmd.node.right = i_s_data[26:18];
        in_cmd.code       = i_s_data[90:27];
    end

    // classify: keep only commands that have an effect
    always_comb begin
        unique case (i_s_func)
            hufd_pkg::FUNC_LOAD:   keep = ({1'b0, in_cmd.idx} < NodeLimit);
            hufd_pkg::FUNC_DECODE: keep = 1'b1;
            hufd_pkg::FUNC_END:    keep = 1'b1;
            default:               keep = 1'b0;
        endcase
    end

    assign o_s_tready  = (r_count != 2'd2);
    assign push        = i_s_tvalid && o_s_tready && keep;
    assign pop         = i_cmd_pop && (r_count != 2'd0);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_cmd;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[design/hufd_back.sv]
// ----------------------------------------------------------------------------
// hufd_back
// Execution side: owns the node table, walks the tree one code bit per
// cycle while not stalled, counts symbols and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hufd_back #(
    parameter int NODE_COUNT = 512,
    parameter int WORD_BITS  = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cmd_valid,
    input  wire hufd_pkg::t_cmd               i_cmd,
    output logic                              o_cmd_pop,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [hufd_pkg::CNT_W-1:0]   i_cfg_wr_data,
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic      [hufd_pkg::SYM_W-1:0]   o_m_sym,
    output hufd_pkg::t_kind                   o_m_kind,
    output logic                              o_m_last
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int CW = $clog2(WORD_BITS + 1);
    localparam int IW = hufd_pkg::IDX_W;
    localparam logic [IW:0] NodeLimit = (IW + 1)'(NODE_COUNT);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]                   r_state;
    logic [WORD_BITS-1:0]         r_word;
    logic [CW-1:0]                r_bits;
    logic                         r_pend;
    logic                         r_pend_oor;
    logic [IW-1:0]                r_pend_idx;
    logic [IW-1:0]                r_cur_idx;
    hufd_pkg::t_node              r_cur;
    hufd_pkg::t_node              r_root;
    logic [hufd_pkg::CNT_W-1:0]   r_count;
    logic [hufd_pkg::CNT_W-1:0]   r_total;
    logic                         r_hold_valid;
    logic [hufd_pkg::SYM_W-1:0]   r_hold_sym;
    logic                         r_out_valid;
    logic [hufd_pkg::SYM_W-1:0]   r_out_sym;
    hufd_pkg::t_kind              r_out_kind;
    logic                         r_out_last;

    hufd_pkg::t_node              rd_node;
    logic                         out_free;
    logic                         res_leaf;
    logic [hufd_pkg::SYM_W-1:0]   res_sym;
    hufd_pkg::t_node              res_node;
    logic [IW-1:0]                res_idx;
    logic                         emit;
    logic                         stall;
    logic [hufd_pkg::CNT_W-1:0]   count_new;
    logic                         more;
    logic [IW-1:0]                nxt;
    logic                         nxt_oor;
    logic                         ram_wr_en;
    logic                         ram_rd_en;
    logic                         is_load;
    logic                         is_decode;
    logic                         is_end;
    logic                         flush_done;

    // node table
    hufd_ram #(
        .WIDTH ($bits(hufd_pkg::t_node)),
        .DEPTH (NODE_COUNT)
    ) u_tree (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (i_cmd.idx[AW-1:0]),
        .i_wr_data (i_cmd.node),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (nxt[AW-1:0]),
        .o_rd_data (rd_node)
    );

    assign out_free = !r_out_valid || i_m_tready;

    // command decode in idle
    assign is_load   = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.func == hufd_pkg::FUNC_LOAD);
    assign is_decode = (r_state == S_IDLE) && i_cmd_valid
                       && (i_cmd.func == hufd_pkg::FUNC_DECODE);
    assign is_end    = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.func == hufd_pkg::FUNC_END)
                       && out_free;
    assign ram_wr_en = is_load;
    assign o_cmd_pop = is_load || is_decode || is_end;

    // resolve the node reached by the previous bit
    always_comb begin
        res_leaf = r_pend && (r_pend_oor || (rd_node.right == '0));
        res_sym  = r_pend_oor ? '0 : rd_node.left[hufd_pkg::SYM_W-1:0];
        if (!r_pend) begin
            res_node = r_cur;
            res_idx  = r_cur_idx;
        end else if (res_leaf) begin
            res_node = r_root;
            res_idx  = '0;
        end else begin
            res_node = rd_node;
            res_idx  = r_pend_idx;
        end
    end

    // step on the next code bit
    assign emit      = (r_state == S_WALK) && res_leaf;
    assign stall     = emit && r_hold_valid && !out_free;
    assign count_new = emit ? (r_count + 1'b1) : r_count;
    assign more      = (r_bits != '0) && (count_new < r_total);
    assign nxt       = r_word[0] ? res_node.right : res_node.left;
    assign nxt_oor   = ({1'b0, nxt} >= NodeLimit);
    assign ram_rd_en = (r_state == S_WALK) && !stall && more && !nxt_oor;

    assign flush_done = (r_state == S_FLUSH) && (!r_hold_valid || out_free);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cfg_wr_en) begin
            r_total <= i_cfg_wr_data;
        end
    end

    // walk control and tree state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend     <= 1'b0;
            r_cur_idx  <= '0;
            r_cur      <= '0;
            r_root     <= '0;
            r_count    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (is_load) begin
                        if (i_cmd.idx == '0) begin
                            r_root <= i_cmd.node;
                        end
                        if (i_cmd.idx == r_cur_idx) begin
                            r_cur <= i_cmd.node;
                        end
                    end else if (is_decode) begin
                        r_state <= S_WALK;
                    end else if (is_end) begin
                        r_count   <= '0;
                        r_cur_idx <= '0;
                        r_cur     <= r_root;
                    end
                end
                S_WALK: begin
                    if (!stall) begin
                        r_count   <= count_new;
                        r_cur     <= res_node;
                        r_cur_idx <= res_idx;
                        if (more) begin
                            r_pend     <= 1'b1;
                            r_pend_oor <= nxt_oor;
                            r_pend_idx <= nxt;
                        end else begin
                            r_pend  <= 1'b0;
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    if (flush_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // code word shifter
    always_ff @(posedge i_clk) begin
        if (is_decode) begin
            r_word <= i_cmd.code[WORD_BITS-1:0];
            r_bits <= CW'(WORD_BITS);
        end else if ((r_state == S_WALK) && !stall && more) begin
            r_word <= r_word >> 1;
            r_bits <= r_bits - 1'b1;
        end
    end

    // one-symbol hold so the final symbol of a word can carry last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else if (emit && !stall) begin
            r_hold_valid <= 1'b1;
        end else if (flush_done) begin
            r_hold_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit && !stall) begin
            r_hold_sym <= res_sym;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (is_end || (emit && !stall && r_hold_valid)
                     || (flush_done && r_hold_valid)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_end) begin
            r_out_sym  <= '0;
            r_out_kind <= (r_count < r_total) ? hufd_pkg::KIND_TRUNC : hufd_pkg::KIND_DONE;
            r_out_last <= 1'b1;
        end else if (emit && !stall && r_hold_valid) begin
            r_out_sym  <= r_hold_sym;
            r_out_kind <= hufd_pkg::KIND_SYMBOL;
            r_out_last <= 1'b0;
        end else if (flush_done && r_hold_valid) begin
            r_out_sym  <= r_hold_sym;
            r_out_kind <= hufd_pkg::KIND_SYMBOL;
            r_out_last <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_sym    = r_out_sym;
    assign o_m_kind   = r_out_kind;
    assign o_m_last   = r_out_last;

endmodule

`default_nettype wire
